/* rtl/ltks_pkg.sv */
// Shared types and constants of the light top-k selector.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package ltks_pkg;

    localparam int unsigned POS_W   = 24;
    localparam int unsigned VAL_W   = 16;
    localparam int unsigned LIGHT_W = 7;
    localparam int unsigned SLOT_W  = 5;
    localparam int unsigned IMP_W   = 40;
    localparam int unsigned BUD_W   = 6;
    localparam int unsigned BON_W   = 10;
    localparam int unsigned CIDX_W  = 3;

    // 0.1 in Q8.8, rounded
    localparam logic [VAL_W-1:0] MIN_RANGE = 16'd26;
    // 1.0 in Q.16, added to the squared distance
    localparam logic [49:0] DEN_ONE = 50'd65536;

    typedef enum logic [CIDX_W-1:0] {
        CFG_CAMERA_X  = 3'd0,
        CFG_CAMERA_Y  = 3'd1,
        CFG_CAMERA_Z  = 3'd2,
        CFG_SHADOWS   = 3'd3,
        CFG_BUDGET    = 3'd4,
        CFG_BONUS     = 3'd5
    } t_cfg_idx;

    typedef enum logic {
        REQ_LIGHT = 1'b0,
        REQ_EOF   = 1'b1
    } t_req;

    typedef struct packed {
        logic                    req_type;
        logic [LIGHT_W-1:0]      light_index;
        logic                    is_directional;
        logic                    in_view;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [VAL_W-1:0]        light_range;
        logic [VAL_W-1:0]        intensity;
    } t_in;

    typedef struct packed {
        logic [LIGHT_W-1:0] selected_light;
        logic [SLOT_W-1:0]  slot_number;
        logic               valid_res;
        logic               last;
    } t_out;

    typedef struct packed {
        logic signed [POS_W-1:0] camera_x;
        logic signed [POS_W-1:0] camera_y;
        logic signed [POS_W-1:0] camera_z;
        logic                    shadows_enabled;
        logic [BUD_W-1:0]        light_budget;
        logic [BON_W-1:0]        holder_gain;
    } t_cfg;

endpackage

`default_nettype wire

/* rtl/light_topk_select_hysteresis_top.sv */
// Top level of the light top-k selector: configuration registers, front queue, back end.
// Depends on ltks_pkg, ltks_front and ltks_back.
`timescale 1ns / 1ps
`default_nettype none

// Each light item carries its position, range and intensity; visible point lights are kept
// as candidates with an importance figure, and an end-of-frame item emits one (light, slot)
// result per chosen light, or one none-result. A stored light goes through the 48-step
// one-bit-a-cycle restoring divider. At frame end, with more candidates than the budget, the
// winners are found by one pass over the stored candidates per slot (one candidate memory read
// a cycle); each result is then read and loaded into the output register once that is free.
// A two-entry queue takes input transfers while the back end works.
module light_topk_select_hysteresis_top #(
    parameter int unsigned MAX_SLOTS   = 8,
    parameter int unsigned LIGHT_TABLE = 128
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_in_valid,
    output logic                              o_in_stall,
    input  ltks_pkg::t_in                     i_in_data,
    output logic                              o_out_valid,
    input  wire                               i_out_stall,
    output ltks_pkg::t_out                    o_out_data,
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire [ltks_pkg::CIDX_W-1:0]        i_cfg_index,
    input  wire [ltks_pkg::POS_W-1:0]         i_cfg_data
);

    ltks_pkg::t_cfg r_cfg;
    logic           q_valid;
    ltks_pkg::t_in  q_data;
    logic           q_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.camera_x        <= '0;
            r_cfg.camera_y        <= '0;
            r_cfg.camera_z        <= '0;
            r_cfg.shadows_enabled <= 1'b1;
            r_cfg.light_budget    <= 6'd8;
            r_cfg.holder_gain     <= 10'd346;
        end else if (i_cfg_valid) begin
            unique case (ltks_pkg::t_cfg_idx'(i_cfg_index))
                ltks_pkg::CFG_CAMERA_X: r_cfg.camera_x <= i_cfg_data;
                ltks_pkg::CFG_CAMERA_Y: r_cfg.camera_y <= i_cfg_data;
                ltks_pkg::CFG_CAMERA_Z: r_cfg.camera_z <= i_cfg_data;
                ltks_pkg::CFG_SHADOWS:  r_cfg.shadows_enabled <= i_cfg_data[0];
                ltks_pkg::CFG_BUDGET:   r_cfg.light_budget <= i_cfg_data[ltks_pkg::BUD_W-1:0];
                ltks_pkg::CFG_BONUS:    r_cfg.holder_gain <= i_cfg_data[ltks_pkg::BON_W-1:0];
                default: ;
            endcase
        end
    end

    ltks_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_q_valid  (q_valid),
        .o_q_data   (q_data),
        .i_q_pop    (q_pop)
    );

    ltks_back #(
        .MAX_SLOTS   (MAX_SLOTS),
        .LIGHT_TABLE (LIGHT_TABLE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_q_data    (q_data),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

/* rtl/ltks_front.sv */
// Front end: two-entry queue that takes input transfers and hands them to the back end.
// Depends on ltks_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ltks_front (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_stall,
    input  ltks_pkg::t_in    i_in_data,
    output logic             o_q_valid,
    output ltks_pkg::t_in    o_q_data,
    input  wire              i_q_pop
);

    ltks_pkg::t_in r_buf [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_in_stall = (r_cnt == 2'd2);
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_data   = r_buf[r_rd];
    assign push       = i_in_valid && !o_in_stall;
    assign pop        = o_q_valid && i_q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= !r_wr;
            end
            if (pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wr] <= i_in_data;
        end
    end

endmodule

`default_nettype wire

/* rtl/ltks_back.sv */
// Back end: importance figure (squares, serial divider, bonus), candidate store,
// top-k scan at frame end and result output register. Depends on ltks_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ltks_back #(
    parameter int unsigned MAX_SLOTS   = 8,
    parameter int unsigned LIGHT_TABLE = 128
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  ltks_pkg::t_cfg   i_cfg,
    input  wire              i_q_valid,
    input  ltks_pkg::t_in    i_q_data,
    output logic             o_q_pop,
    output logic             o_out_valid,
    input  wire              i_out_stall,
    output ltks_pkg::t_out   o_out_data
);

    localparam int unsigned AW = $clog2(LIGHT_TABLE);
    localparam int unsigned CW = $clog2(LIGHT_TABLE + 1);
    localparam int unsigned SW = $clog2(MAX_SLOTS + 1);
    localparam int unsigned IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int unsigned EW = ltks_pkg::IMP_W + ltks_pkg::LIGHT_W;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b00000001,
        ST_SQ    = 8'b00000010,
        ST_DIV   = 8'b00000100,
        ST_BONUS = 8'b00001000,
        ST_SCAN  = 8'b00010000,
        ST_ORD   = 8'b00100000,
        ST_OWAIT = 8'b01000000,
        ST_ONONE = 8'b10000000
    } t_state;

    t_state r_state;

    ltks_pkg::t_in r_item;
    logic [1:0]    r_axis;
    logic [49:0]   r_den;
    logic [31:0]   r_num;
    logic [49:0]   r_rem;
    logic [47:0]   r_dvd;
    logic [31:0]   r_q;
    logic [5:0]    r_step;

    logic [EW-1:0] r_cand [LIGHT_TABLE];
    logic [EW-1:0] r_rd_q;
    logic [CW-1:0] r_cnt;
    logic [LIGHT_TABLE-1:0] r_inc;
    logic [LIGHT_TABLE-1:0] r_taken;

    logic [SW-1:0] r_n;
    logic          r_over;
    logic [SW-1:0] r_slot;
    logic [SW-1:0] r_oslot;
    logic [AW-1:0] r_sel [MAX_SLOTS];
    logic [CW-1:0] r_ptr;
    logic          r_q_vld;
    logic [AW-1:0] r_q_idx;
    logic          r_best_vld;
    logic [AW-1:0] r_best_idx;
    logic [ltks_pkg::IMP_W-1:0] r_best_imp;

    logic          r_ov;
    ltks_pkg::t_out r_out;

    // datapath terms
    logic signed [ltks_pkg::POS_W-1:0] pos_s;
    logic signed [ltks_pkg::POS_W-1:0] cam_s;
    logic signed [ltks_pkg::POS_W:0]   dlt;
    logic [ltks_pkg::POS_W-1:0]        dabs;
    logic [47:0]                       dsq;
    logic [ltks_pkg::VAL_W-1:0]        rng;
    logic [50:0]                       trial;
    logic                              ge;
    logic [41:0]                       bprod;
    logic                              inc_hit;
    logic [ltks_pkg::IMP_W-1:0]        imp;
    logic                              rd_en;
    logic [AW-1:0]                     rd_addr;
    logic                              out_free;
    logic                              out_load;
    logic                              skip;
    logic [SW-1:0]                     bud;
    logic                              in_tab;
    logic [ltks_pkg::LIGHT_W-1:0]      rd_light;
    logic                              better;
    logic                              scan_issue;

    always_comb begin
        unique case (r_axis)
            2'd0:    begin pos_s = r_item.pos_x; cam_s = i_cfg.camera_x; end
            2'd1:    begin pos_s = r_item.pos_y; cam_s = i_cfg.camera_y; end
            default: begin pos_s = r_item.pos_z; cam_s = i_cfg.camera_z; end
        endcase
    end

    assign dlt   = {pos_s[ltks_pkg::POS_W-1], pos_s} - {cam_s[ltks_pkg::POS_W-1], cam_s};
    assign dabs  = dlt[ltks_pkg::POS_W] ? ltks_pkg::POS_W'(-dlt) : dlt[ltks_pkg::POS_W-1:0];
    assign dsq   = dabs * dabs;
    assign rng   = (r_item.light_range < ltks_pkg::MIN_RANGE) ? ltks_pkg::MIN_RANGE
                                                              : r_item.light_range;
    assign trial = {r_rem, r_dvd[47]};
    assign ge    = (trial >= {1'b0, r_den});
    assign bprod = r_q * i_cfg.holder_gain;
    assign in_tab  = ({1'b0, r_item.light_index} < 8'(LIGHT_TABLE));
    assign inc_hit = in_tab && r_inc[r_item.light_index[AW-1:0]];
    // shifted product stays below 2^34, so the 40-bit ceiling is never reached
    assign imp   = inc_hit ? ltks_pkg::IMP_W'(bprod >> 8) : ltks_pkg::IMP_W'(r_q);

    assign out_free = !r_ov || !i_out_stall;
    assign out_load = out_free && ((r_state == ST_OWAIT) || (r_state == ST_ONONE));
    assign skip = !i_cfg.shadows_enabled || i_q_data.is_directional || !i_q_data.in_view ||
                  (r_cnt >= CW'(LIGHT_TABLE));
    assign bud  = (i_cfg.light_budget > ltks_pkg::BUD_W'(MAX_SLOTS)) ? SW'(MAX_SLOTS)
                                                                   : SW'(i_cfg.light_budget);
    assign o_q_pop = (r_state == ST_IDLE);

    assign scan_issue = (r_state == ST_SCAN) && (r_ptr < r_cnt);
    assign rd_en   = scan_issue || (r_state == ST_ORD);
    assign rd_addr = (r_state == ST_SCAN) ? r_ptr[AW-1:0]
                   : (r_over ? r_sel[r_oslot[IW-1:0]] : AW'(r_oslot));
    assign rd_light = r_rd_q[ltks_pkg::LIGHT_W-1:0];
    assign better = r_q_vld && !r_taken[r_q_idx] &&
                    (!r_best_vld || (r_rd_q[EW-1:ltks_pkg::LIGHT_W] > r_best_imp));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_cnt      <= '0;
            r_inc      <= '0;
            r_taken    <= '0;
            r_ov       <= 1'b0;
            r_q_vld    <= 1'b0;
            r_best_vld <= 1'b0;
        end else begin
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
            r_q_vld <= scan_issue;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        if (i_q_data.req_type == ltks_pkg::REQ_EOF) begin
                            r_inc   <= '0;
                            r_taken <= '0;
                            r_slot  <= '0;
                            r_oslot <= '0;
                            r_ptr   <= '0;
                            r_best_vld <= 1'b0;
                            r_over  <= (8'(r_cnt) > 8'(bud));
                            r_n     <= (8'(r_cnt) > 8'(bud)) ? bud : SW'(r_cnt);
                            if (!i_cfg.shadows_enabled || r_cnt == '0 || bud == '0) begin
                                r_cnt   <= '0;
                                r_state <= ST_ONONE;
                            end else if (8'(r_cnt) > 8'(bud)) begin
                                r_state <= ST_SCAN;
                            end else begin
                                r_state <= ST_ORD;
                            end
                        end else if (!skip) begin
                            r_state <= ST_SQ;
                        end
                    end
                end
                ST_SQ: begin
                    if (r_axis == 2'd2) begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (r_step == 6'd47) begin
                        r_state <= ST_BONUS;
                    end
                end
                ST_BONUS: begin
                    r_cnt   <= r_cnt + 1'b1;
                    r_state <= ST_IDLE;
                end
                ST_SCAN: begin
                    if (better) begin
                        r_best_vld <= 1'b1;
                    end
                    // close the pass once every entry has been read and compared
                    if (!scan_issue && !r_q_vld) begin
                        r_taken[r_best_idx] <= 1'b1;
                        r_best_vld <= 1'b0;
                        r_ptr      <= '0;
                        r_slot     <= r_slot + 1'b1;
                        if (r_slot + 1'b1 == r_n) begin
                            r_state <= ST_ORD;
                        end
                    end else if (scan_issue) begin
                        r_ptr <= r_ptr + 1'b1;
                    end
                end
                ST_ORD: begin
                    r_state <= ST_OWAIT;
                end
                ST_OWAIT: begin
                    if (out_free) begin
                        r_oslot <= r_oslot + 1'b1;
                        if ({1'b0, rd_light} < 8'(LIGHT_TABLE)) begin
                            r_inc[rd_light[AW-1:0]] <= 1'b1;
                        end
                        if (r_oslot + 1'b1 == r_n) begin
                            r_cnt   <= '0;
                            r_state <= ST_IDLE;
                        end else begin
                            r_state <= ST_ORD;
                        end
                    end
                end
                ST_ONONE: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_q <= r_cand[rd_addr];
        end
        r_q_idx <= r_ptr[AW-1:0];
        unique case (r_state)
            ST_IDLE: begin
                r_item <= i_q_data;
                r_axis <= 2'd0;
                r_den  <= ltks_pkg::DEN_ONE;
            end
            ST_SQ: begin
                r_den  <= r_den + 50'(dsq);
                r_axis <= r_axis + 1'b1;
                if (r_axis == 2'd0) begin
                    r_num <= r_item.intensity * rng;
                end
                r_rem  <= '0;
                r_step <= '0;
                r_dvd  <= {r_num, 16'd0};
            end
            ST_DIV: begin
                r_rem  <= ge ? 50'(trial - {1'b0, r_den}) : trial[49:0];
                r_q    <= {r_q[30:0], ge};
                r_dvd  <= {r_dvd[46:0], 1'b0};
                r_step <= r_step + 1'b1;
            end
            ST_BONUS: begin
                r_cand[r_cnt[AW-1:0]] <= {imp, r_item.light_index};
            end
            ST_SCAN: begin
                if (better) begin
                    r_best_idx <= r_q_idx;
                    r_best_imp <= r_rd_q[EW-1:ltks_pkg::LIGHT_W];
                end
                if (!scan_issue && !r_q_vld) begin
                    r_sel[r_slot[IW-1:0]] <= r_best_idx;
                end
            end
            ST_OWAIT: begin
                if (out_free) begin
                    r_out.selected_light <= rd_light;
                    r_out.slot_number    <= ltks_pkg::SLOT_W'(r_oslot);
                    r_out.valid_res      <= 1'b1;
                    r_out.last           <= (r_oslot + 1'b1 == r_n);
                end
            end
            ST_ONONE: begin
                if (out_free) begin
                    r_out <= '{selected_light: '0, slot_number: '0,
                               valid_res: 1'b0, last: 1'b1};
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

/* rtl/ltks_checker.sv */
// Port-level checks of the light top-k selector, bound to the top level.
// Depends on ltks_pkg and light_topk_select_hysteresis_top.
`timescale 1ns / 1ps
`default_nettype none

module ltks_checker #(
    parameter int unsigned MAX_SLOTS = 8
) (
    input wire                        i_clk,
    input wire                        i_rst_n,
    input wire                        o_out_valid,
    input wire                        i_out_stall,
    input ltks_pkg::t_out             o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_none_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.valid_res |->
            o_out_data.last && o_out_data.selected_light == '0 &&
            o_out_data.slot_number == '0)
        else $error("malformed none-result");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.valid_res |->
            (32'(o_out_data.slot_number) < MAX_SLOTS))
        else $error("slot beyond slot count");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown straight after reset");

endmodule

bind light_topk_select_hysteresis_top ltks_checker #(.MAX_SLOTS(MAX_SLOTS)) u_ltks_checker (.*);

`default_nettype wire
